[hw/rtl/assert_macros.svh]
// Assertion helper macros for the light selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/nls_pkg.sv]
// ----------------------------------------------------------------------------
// nls_pkg
// Types and constants shared by the light selector files.
// ----------------------------------------------------------------------------
package nls_pkg;
    localparam int LIGHT_SLOTS = 64;
    localparam int MAX_PICK    = 4;
    localparam int SLOT_W      = $clog2(LIGHT_SLOTS);
    localparam int CNT_W       = $clog2(MAX_PICK + 1);
    localparam int PICK_W      = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int COORD_W     = 20;
    localparam int RANGE_W     = 19;
    // Light record: kind, position and range.
    localparam int REC_W       = 2 + 3 * COORD_W + RANGE_W;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_SPOT  = 2'd2;
    localparam logic [1:0] KIND_DIR   = 2'd3;
    localparam logic       OP_WRITE   = 1'b0;
    localparam logic       OP_QUERY   = 1'b1;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic [RANGE_W-1:0]         rng;
    } light_rec_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_EMPTY = 5'b10000
    } state_t;
endpackage

[hw/rtl/nls_ram.sv]
// ----------------------------------------------------------------------------
// nls_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/nearest_light_selector.sv]
// ----------------------------------------------------------------------------
// nearest_light_selector
// Light table in RAM; a query scans all slots, keeps a sorted top list and
// emits the picks that pass the range cube test.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  in        input      in_valid/stall   op, slot, kind, coords, range
//  out       output     out_valid/stall  picked_slot, picked_valid, last
//  cfg       input      cfg_valid/ready  cfg_data (lighting_enable)
//
// A write is done while idle and leaves the block idle. A query is accepted
// while idle; the scan then walks every slot through the single RAM read
// port, with the read and key stages behind it. The emit phase steps through
// each held candidate, and an empty selection ends with a single item; a
// disabled query goes straight to that item. After reset the RAM is cleared
// one slot per cycle; no item is accepted meanwhile. A stalled result holds
// until taken.
module nearest_light_selector
    import nls_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [SLOT_W-1:0]           slot,
    input  logic [1:0]                  kind,
    input  logic signed [COORD_W-1:0]   coord_a_x,
    input  logic signed [COORD_W-1:0]   coord_a_y,
    input  logic signed [COORD_W-1:0]   coord_a_z,
    input  logic signed [COORD_W-1:0]   box_max_x,
    input  logic signed [COORD_W-1:0]   box_max_y,
    input  logic signed [COORD_W-1:0]   box_max_z,
    input  logic [RANGE_W-1:0]          light_range,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [SLOT_W-1:0]           picked_slot,
    output logic                        picked_valid,
    output logic                        last
);
`include "assert_macros.svh"

    localparam int KEY_W = 2 * (COORD_W + 2) + 2;

    state_t state_reg, state_next;
    logic   enable_reg;
    logic [SLOT_W:0] cnt_reg;
    logic   rd_v_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic   k_v_reg;
    logic [SLOT_W-1:0] k_slot_reg;
    light_rec_t k_rec_reg;
    logic [KEY_W-1:0] k_key_reg;
    logic signed [COORD_W:0] cx_reg, cy_reg, cz_reg;
    logic signed [COORD_W-1:0] bminx_reg, bminy_reg, bminz_reg;
    logic signed [COORD_W-1:0] bmaxx_reg, bmaxy_reg, bmaxz_reg;
    logic [CNT_W-1:0] top_cnt_reg;
    logic [SLOT_W-1:0] top_slot_reg [MAX_PICK];
    logic [KEY_W-1:0]  top_key_reg  [MAX_PICK];
    logic              top_dir_reg  [MAX_PICK];
    logic              top_take_reg [MAX_PICK];
    logic [PICK_W-1:0] emit_idx_reg;
    logic              emitted_reg;

    // RAM ports.
    logic we;
    logic [SLOT_W-1:0] waddr, raddr;
    light_rec_t wrec, rrec;

    nls_ram #(.WIDTH(REC_W), .DEPTH(LIGHT_SLOTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
        .raddr(raddr), .rdata(rrec)
    );

    logic in_acc, scan_done;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign scan_done = (cnt_reg == (SLOT_W+1)'(LIGHT_SLOTS)) && !rd_v_reg && !k_v_reg;

    // Write port: clearing pass or a light write.
    always_comb
    begin
        we    = 1'b0;
        waddr = slot;
        wrec  = '{kind, coord_a_x, coord_a_y, coord_a_z, light_range};
        if (state_reg == ST_CLEAR)
        begin
            we    = 1'b1;
            waddr = cnt_reg[SLOT_W-1:0];
            wrec  = '0;
        end
        else if (in_acc && op == OP_WRITE)
        begin
            we = 1'b1;
        end
    end
    assign raddr = cnt_reg[SLOT_W-1:0];

    // Key stage: squared distance from doubled centre.
    logic signed [COORD_W+1:0] dx, dy, dz;
    logic signed [2*(COORD_W+2)-1:0] sqx, sqy, sqz;
    logic [KEY_W-1:0] key_c;
    always_comb
    begin
        dx = (COORD_W+2)'(cx_reg) - ((COORD_W+2)'(rrec.px) <<< 1);
        dy = (COORD_W+2)'(cy_reg) - ((COORD_W+2)'(rrec.py) <<< 1);
        dz = (COORD_W+2)'(cz_reg) - ((COORD_W+2)'(rrec.pz) <<< 1);
        sqx = dx * dx;
        sqy = dy * dy;
        sqz = dz * dz;
        key_c = KEY_W'($unsigned(sqx)) + KEY_W'($unsigned(sqy))
              + KEY_W'($unsigned(sqz));
    end

    // Range cube test for the candidate in the key stage.
    logic take_c;
    logic signed [COORD_W+1:0] r_s;
    always_comb
    begin
        r_s = (COORD_W+2)'(signed'({1'b0, k_rec_reg.rng}));
        take_c = (k_rec_reg.kind == KIND_DIR) ||
            ((COORD_W+2)'(bminx_reg) <= (COORD_W+2)'(k_rec_reg.px) + r_s &&
             (COORD_W+2)'(k_rec_reg.px) - r_s <= (COORD_W+2)'(bmaxx_reg) &&
             (COORD_W+2)'(bminy_reg) <= (COORD_W+2)'(k_rec_reg.py) + r_s &&
             (COORD_W+2)'(k_rec_reg.py) - r_s <= (COORD_W+2)'(bmaxy_reg) &&
             (COORD_W+2)'(bminz_reg) <= (COORD_W+2)'(k_rec_reg.pz) + r_s &&
             (COORD_W+2)'(k_rec_reg.pz) - r_s <= (COORD_W+2)'(bmaxz_reg));
    end

    // Insertion compare against each held entry.
    logic ahead_of [MAX_PICK];
    logic k_dir;
    assign k_dir = (k_rec_reg.kind == KIND_DIR);
    always_comb
    begin
        for (int i = 0; i < MAX_PICK; i++)
        begin
            if (i >= int'(top_cnt_reg))
                ahead_of[i] = 1'b1;
            else if (k_dir != top_dir_reg[i])
                ahead_of[i] = k_dir;
            else if (k_dir)
                ahead_of[i] = k_slot_reg > top_slot_reg[i];
            else
                ahead_of[i] = k_key_reg < top_key_reg[i];
        end
    end

    // Whether any taken entry lies after the emit index.
    logic more_take;
    always_comb
    begin
        more_take = 1'b0;
        for (int i = 0; i < MAX_PICK; i++)
        begin
            if (i > int'(emit_idx_reg) && i < int'(top_cnt_reg) && top_take_reg[i])
                more_take = 1'b1;
        end
    end

    // The entry at the emit index is held and passes.
    logic cur_take;
    assign cur_take = (int'(emit_idx_reg) < int'(top_cnt_reg)) && top_take_reg[emit_idx_reg];

    logic out_acc;
    assign out_acc = out_valid && !out_stall;

    // Output view.
    always_comb
    begin
        out_valid    = 1'b0;
        picked_slot  = top_slot_reg[emit_idx_reg];
        picked_valid = 1'b1;
        last         = !more_take;
        if (state_reg == ST_EMPTY)
        begin
            out_valid    = 1'b1;
            picked_slot  = '0;
            picked_valid = 1'b0;
            last         = 1'b1;
        end
        else if (state_reg == ST_EMIT)
        begin
            out_valid = cur_take;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (cnt_reg == (SLOT_W+1)'(LIGHT_SLOTS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc && op != OP_WRITE)
                    state_next = enable_reg ? ST_SCAN : ST_EMPTY;
            ST_SCAN:
                if (scan_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (cur_take)
                begin
                    if (out_acc && last)
                        state_next = ST_IDLE;
                end
                else if (!more_take)
                    state_next = emitted_reg ? ST_IDLE : ST_EMPTY;
            ST_EMPTY:
                if (out_acc)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            enable_reg   <= 1'b0;
            cnt_reg      <= '0;
            rd_v_reg     <= 1'b0;
            k_v_reg      <= 1'b0;
            top_cnt_reg  <= '0;
            emit_idx_reg <= '0;
            emitted_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                enable_reg <= cfg_data;
            rd_v_reg <= 1'b0;
            k_v_reg  <= rd_v_reg && (rrec.kind != KIND_EMPTY);
            case (state_reg)
                ST_CLEAR:
                    cnt_reg <= (cnt_reg == (SLOT_W+1)'(LIGHT_SLOTS - 1)) ? '0 : cnt_reg + 1'b1;
                ST_IDLE:
                begin
                    cnt_reg      <= '0;
                    top_cnt_reg  <= '0;
                    emit_idx_reg <= '0;
                    emitted_reg  <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (cnt_reg != (SLOT_W+1)'(LIGHT_SLOTS))
                    begin
                        rd_v_reg <= 1'b1;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                    if (k_v_reg && top_cnt_reg != CNT_W'(MAX_PICK))
                        top_cnt_reg <= top_cnt_reg + 1'b1;
                end
                ST_EMIT:
                    if (!cur_take || out_acc)
                    begin
                        if (out_acc)
                            emitted_reg <= 1'b1;
                        if (more_take)
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                    end
                default:
                    ;
            endcase
        end
    end

    // Payload registers: query box, key stage and sorted top list.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cx_reg <= (COORD_W+1)'(coord_a_x) + (COORD_W+1)'(box_max_x);
            cy_reg <= (COORD_W+1)'(coord_a_y) + (COORD_W+1)'(box_max_y);
            cz_reg <= (COORD_W+1)'(coord_a_z) + (COORD_W+1)'(box_max_z);
            bminx_reg <= coord_a_x; bminy_reg <= coord_a_y; bminz_reg <= coord_a_z;
            bmaxx_reg <= box_max_x; bmaxy_reg <= box_max_y; bmaxz_reg <= box_max_z;
        end
        rd_slot_reg <= raddr;
        k_slot_reg  <= rd_slot_reg;
        k_rec_reg   <= rrec;
        k_key_reg   <= (rrec.kind == KIND_DIR) ? '0 : key_c;
        if (state_reg == ST_SCAN && k_v_reg)
        begin
            for (int i = 0; i < MAX_PICK; i++)
            begin
                if (ahead_of[i])
                begin
                    if (i == 0 || !ahead_of[(i > 0) ? i - 1 : 0])
                    begin
                        top_slot_reg[i] <= k_slot_reg;
                        top_key_reg[i]  <= k_key_reg;
                        top_dir_reg[i]  <= k_dir;
                        top_take_reg[i] <= take_c;
                    end
                    else
                    begin
                        top_slot_reg[i] <= top_slot_reg[(i > 0) ? i - 1 : 0];
                        top_key_reg[i]  <= top_key_reg[(i > 0) ? i - 1 : 0];
                        top_dir_reg[i]  <= top_dir_reg[(i > 0) ? i - 1 : 0];
                        top_take_reg[i] <= top_take_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    // Checks on the sequencing.
    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !in_acc)
    `ASSERT_IMPL(a_out_only_emit, clk, rst_n, out_valid,
        state_reg == ST_EMIT || state_reg == ST_EMPTY)
    `ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(picked_slot))
endmodule

[dv/nearest_light_selector_tb.sv]
// ----------------------------------------------------------------------------
// Nearest light selector testbench
// Drives light writes and box queries with random gaps on both channels,
// predicts the selected slots with a behavioral model of the light table and
// checks every result item in order. The enable register is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module nearest_light_selector_tb;
    import nls_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    // Expected result of one pick.
    typedef struct {
        logic [SLOT_W-1:0] slot_no;
        logic              sel_valid;
        logic              sel_last;
    } pick_t;

    // Input item as driven on the ports.
    typedef struct {
        logic                      op;
        logic [SLOT_W-1:0]         slot;
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
        logic [RANGE_W-1:0]        rng;
    } light_item_t;

    // Light table model and queue of expected picks.
    class pick_scoreboard;
        logic [1:0]                tbl_kind[LIGHT_SLOTS];
        logic signed [COORD_W-1:0] tbl_x[LIGHT_SLOTS];
        logic signed [COORD_W-1:0] tbl_y[LIGHT_SLOTS];
        logic signed [COORD_W-1:0] tbl_z[LIGHT_SLOTS];
        logic [RANGE_W-1:0]        tbl_rng[LIGHT_SLOTS];
        logic                      enable;
        pick_t                     pending[$];
        int                        errors;

        function void clear();
            for (int i = 0; i < LIGHT_SLOTS; i++)
            begin
                tbl_kind[i] = KIND_EMPTY;
                tbl_x[i] = '0;
                tbl_y[i] = '0;
                tbl_z[i] = '0;
                tbl_rng[i] = '0;
            end
            enable = 1'b0;
            errors = 0;
        endfunction

        // True when slot a ranks ahead of slot b.
        function bit ahead(int a, int b, longint unsigned ka, longint unsigned kb);
            bit da;
            bit db;
            da = (tbl_kind[a] == KIND_DIR);
            db = (tbl_kind[b] == KIND_DIR);
            if (da != db)
                return da;
            if (da)
                return a > b;
            if (ka != kb)
                return ka < kb;
            return a < b;
        endfunction

        function longint unsigned sqr(longint d);
            longint unsigned u;
            u = (d < 0) ? -d : d;
            return u * u;
        endfunction

        // Note an accepted input item and queue the picks it causes.
        function void note_item(light_item_t it);
            longint unsigned keys[LIGHT_SLOTS];
            int     top[MAX_PICK];
            int     cnt;
            int     j;
            int     n;
            longint cx, cy, cz, r, px, py, pz;
            bit     take;
            pick_t  p;
            cnt = 0;
            n = 0;
            if (it.op == OP_WRITE)
            begin
                tbl_kind[it.slot] = it.kind;
                tbl_x[it.slot] = it.ax;
                tbl_y[it.slot] = it.ay;
                tbl_z[it.slot] = it.az;
                tbl_rng[it.slot] = it.rng;
                return;
            end
            if (enable)
            begin
                cx = longint'(it.ax) + longint'(it.bx);
                cy = longint'(it.ay) + longint'(it.by);
                cz = longint'(it.az) + longint'(it.bz);
                for (int s = 0; s < LIGHT_SLOTS; s++)
                begin
                    if (tbl_kind[s] == KIND_EMPTY)
                        continue;
                    if (tbl_kind[s] != KIND_DIR)
                        keys[s] = sqr(cx - 2 * longint'(tbl_x[s]))
                                + sqr(cy - 2 * longint'(tbl_y[s]))
                                + sqr(cz - 2 * longint'(tbl_z[s]));
                    else
                        keys[s] = 0;
                    j = cnt;
                    while (j > 0 && ahead(s, top[j-1], keys[s], keys[top[j-1]]))
                    begin
                        if (j < MAX_PICK)
                            top[j] = top[j-1];
                        j--;
                    end
                    if (j < MAX_PICK)
                        top[j] = s;
                    if (cnt < MAX_PICK)
                        cnt++;
                end
                for (int k = 0; k < cnt; k++)
                begin
                    if (tbl_kind[top[k]] == KIND_DIR)
                        take = 1'b1;
                    else
                    begin
                        r = tbl_rng[top[k]];
                        px = tbl_x[top[k]];
                        py = tbl_y[top[k]];
                        pz = tbl_z[top[k]];
                        take = it.ax <= px + r && px - r <= it.bx
                            && it.ay <= py + r && py - r <= it.by
                            && it.az <= pz + r && pz - r <= it.bz;
                    end
                    if (take)
                    begin
                        p.slot_no = SLOT_W'(top[k]);
                        p.sel_valid = 1'b1;
                        p.sel_last = 1'b0;
                        pending.push_back(p);
                        n++;
                    end
                end
            end
            if (n == 0)
            begin
                p.slot_no = '0;
                p.sel_valid = 1'b0;
                p.sel_last = 1'b1;
                pending.push_back(p);
            end
            else
                pending[$].sel_last = 1'b1;
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_pick(logic [SLOT_W-1:0] s, logic v, logic l);
            pick_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: picked_slot %0d", s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (s !== e.slot_no)
            begin
                $error("picked_slot: expected %0d, actual %0d", e.slot_no, s);
                errors++;
            end
            if (v !== e.sel_valid)
            begin
                $error("picked_valid: expected %0d, actual %0d", e.sel_valid, v);
                errors++;
            end
            if (l !== e.sel_last)
            begin
                $error("last: expected %0d, actual %0d", e.sel_last, l);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic op;
    logic [SLOT_W-1:0] slot;
    logic [1:0] kind;
    logic signed [COORD_W-1:0] coord_a_x, coord_a_y, coord_a_z;
    logic signed [COORD_W-1:0] box_max_x, box_max_y, box_max_z;
    logic [RANGE_W-1:0] light_range;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    logic out_valid;
    logic out_stall;
    logic [SLOT_W-1:0] picked_slot;
    logic picked_valid;
    logic last;

    pick_scoreboard sb;
    int  cycles;
    int  stall_run;
    bit  stall_quiet;
    logic [SLOT_W-1:0] hot_slot;

    nearest_light_selector dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .slot(slot), .kind(kind),
        .coord_a_x(coord_a_x), .coord_a_y(coord_a_y), .coord_a_z(coord_a_z),
        .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
        .light_range(light_range),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .picked_slot(picked_slot), .picked_valid(picked_valid), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: sample at the rising edge, stall at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pick(picked_slot, picked_valid, last);
    end

    // Stalls are mostly single cycles, with an occasional long run.
    always @(negedge clk)
    begin
        if (stall_quiet)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            out_stall <= 1'b1;
            stall_run = $urandom_range(10, 50);
        end
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Random gap before an item: mostly short, a few long.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Present one item and hold it until accepted. The task returns at the
    // falling edge after acceptance; the caller then drops valid or drives
    // the next item.
    task automatic send_item(light_item_t it);
        idle_gap();
        op <= it.op;
        slot <= it.slot;
        kind <= it.kind;
        coord_a_x <= it.ax;
        coord_a_y <= it.ay;
        coord_a_z <= it.az;
        box_max_x <= it.bx;
        box_max_y <= it.by;
        box_max_z <= it.bz;
        light_range <= it.rng;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
    endtask

    // Wait for every expected pick, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LIGHT_SLOTS + 20) @(negedge clk);
    endtask

    // Write the enable register; only called while idle.
    task automatic write_enable(logic en);
        in_valid <= 1'b0;
        cfg_data <= en;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.enable = en;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(bit near);
        if (near)
            return COORD_W'($signed(COORD_W'($urandom_range(0, 8191))) - 4096);
        case ($urandom_range(0, 5))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic light_item_t make_write(int s, logic [1:0] k, bit near);
        light_item_t it;
        it.op = OP_WRITE;
        it.slot = SLOT_W'(s);
        it.kind = k;
        it.ax = rand_coord(near);
        it.ay = rand_coord(near);
        it.az = rand_coord(near);
        it.bx = COORD_W'($urandom);
        it.by = COORD_W'($urandom);
        it.bz = COORD_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            it.rng = {RANGE_W{1'b1}};
        else
            it.rng = near ? RANGE_W'($urandom_range(0, 4096)) : RANGE_W'($urandom);
        return it;
    endfunction

    function automatic light_item_t make_query(bit near);
        light_item_t it;
        logic signed [COORD_W-1:0] t;
        it.op = OP_QUERY;
        it.slot = SLOT_W'($urandom);
        it.kind = 2'($urandom);
        it.rng = RANGE_W'($urandom);
        it.ax = rand_coord(near);
        it.ay = rand_coord(near);
        it.az = rand_coord(near);
        it.bx = rand_coord(near);
        it.by = rand_coord(near);
        it.bz = rand_coord(near);
        // Mostly well-formed boxes; sometimes leave one inverted.
        if ($urandom_range(0, 5) != 0)
        begin
            if (it.ax > it.bx) begin t = it.ax; it.ax = it.bx; it.bx = t; end
            if (it.ay > it.by) begin t = it.ay; it.ay = it.by; it.by = t; end
            if (it.az > it.bz) begin t = it.az; it.az = it.bz; it.bz = t; end
        end
        return it;
    endfunction

    initial
    begin
        light_item_t it;
        int near_mode;
        sb = new();
        sb.clear();
        cycles = 0;
        stall_run = 0;
        stall_quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_WRITE;
        slot = '0;
        kind = KIND_EMPTY;
        coord_a_x = '0;
        coord_a_y = '0;
        coord_a_z = '0;
        box_max_x = '0;
        box_max_y = '0;
        box_max_z = '0;
        light_range = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        out_stall = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: query while disabled and with an empty table.
        sb.enable = 1'b0;
        send_item(make_query(1'b1));
        drain();
        write_enable(1'b0);
        send_item(make_query(1'b0));
        drain();
        write_enable(1'b1);
        send_item(make_query(1'b1));
        // Extreme slots, each kind, extreme coordinates and ranges.
        it = make_write(0, KIND_POINT, 1'b1);
        it.ax = '0; it.ay = '0; it.az = '0; it.rng = '0;
        send_item(it);
        it = make_write(LIGHT_SLOTS - 1, KIND_DIR, 1'b0);
        send_item(it);
        it = make_write(1, KIND_DIR, 1'b0);
        send_item(it);
        it = make_write(2, KIND_SPOT, 1'b0);
        it.ax = {1'b1, {(COORD_W-1){1'b0}}};
        it.ay = {1'b0, {(COORD_W-1){1'b1}}};
        it.az = {1'b1, {(COORD_W-1){1'b0}}};
        it.rng = {RANGE_W{1'b1}};
        send_item(it);
        // Two lights at one spot for a tie in key.
        it = make_write(5, KIND_POINT, 1'b1);
        send_item(it);
        it.slot = SLOT_W'(4);
        send_item(it);
        it = make_query(1'b1);
        it.ax = {1'b1, {(COORD_W-1){1'b0}}};
        it.ay = {1'b1, {(COORD_W-1){1'b0}}};
        it.az = {1'b1, {(COORD_W-1){1'b0}}};
        it.bx = {1'b0, {(COORD_W-1){1'b1}}};
        it.by = {1'b0, {(COORD_W-1){1'b1}}};
        it.bz = {1'b0, {(COORD_W-1){1'b1}}};
        send_item(it);
        it = make_query(1'b1);
        it.ax = COORD_W'(100); it.bx = COORD_W'(-100);
        send_item(it);
        // Clear a directional slot, then query again.
        send_item(make_write(1, KIND_EMPTY, 1'b0));
        send_item(make_query(1'b1));
        send_item(make_query(1'b0));
        drain();

        // Random phases with enable changes at idle points.
        for (int ph = 0; ph < 7; ph++)
        begin
            write_enable((ph == 3) ? 1'b0 : 1'b1);
            near_mode = $urandom_range(0, 3);
            stall_quiet = (ph == 5);
            for (int i = 0; i < 48; i++)
            begin
                if ($urandom_range(0, 99) < 45)
                begin
                    hot_slot = (near_mode == 0) ? SLOT_W'($urandom_range(0, 11))
                                                : SLOT_W'($urandom);
                    send_item(make_write(hot_slot, 2'($urandom), near_mode != 3));
                end
                else
                    send_item(make_query(near_mode != 3 || $urandom_range(0, 1)));
                if (i == 24 && ph == 2)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end
        stall_quiet = 1'b0;

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
